// File: rtl/sip4_pkg.sv
`default_nettype none

package sip4_pkg;

    typedef logic [7:0] pix_t;

    typedef enum logic [3:0] {
        MODE_DC = 4'd0,
        MODE_TM = 4'd1,
        MODE_VE = 4'd2,
        MODE_HE = 4'd3,
        MODE_LD = 4'd4,
        MODE_RD = 4'd5,
        MODE_VR = 4'd6,
        MODE_VL = 4'd7,
        MODE_HD = 4'd8,
        MODE_HU = 4'd9
    } mode_t;

    localparam pix_t PAD_TOP  = 8'd127;
    localparam pix_t PAD_LEFT = 8'd129;

    // Edge path, index 0 to 14: L3, L3, L2, L1, L0, corner, T0..T7, T7.
    localparam int EDGE_LEN = 15;

    typedef struct packed {
        mode_t                   kind;
        pix_t [EDGE_LEN-1:0]     x;
    } edge_t;

    typedef struct packed {
        mode_t              kind;
        pix_t               dc;
        pix_t               l3;
        pix_t [3:0]         top;
        logic [3:0][8:0]    lc;
        pix_t [9:1]         a2;
        pix_t [12:0]        a3;
    } filt_t;

    function automatic pix_t avg2(input pix_t x, input pix_t y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y} + 9'd1;
        return s[8:1];
    endfunction

    function automatic pix_t avg3(input pix_t x, input pix_t y, input pix_t z);
        logic [9:0] s;
        s = {2'b00, x} + {1'b0, y, 1'b0} + {2'b00, z} + 10'd2;
        return s[9:2];
    endfunction

endpackage

`default_nettype wire

// File: rtl/sip4_edge.sv
`default_nettype none

module sip4_edge (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [3:0]         kind,
    input  wire logic [31:0]        top_edge,
    input  wire logic [31:0]        top_right_edge,
    input  wire logic [31:0]        left_edge,
    input  wire logic [7:0]         corner_pixel,
    input  wire logic               top_avail,
    input  wire logic               left_avail,
    input  wire logic               corner_avail,
    input  wire logic               top_right_avail,
    output logic                    out_valid,
    output sip4_pkg::edge_t         out_data
);
    import sip4_pkg::*;

    logic  valid_reg;
    edge_t data_reg;
    edge_t data_next;

    always_comb begin
        pix_t t3;
        t3 = top_avail ? top_edge[31:24] : PAD_TOP;
        data_next.kind = mode_t'(kind);
        for (int i = 0; i < 4; i++) begin
            data_next.x[4-i] = left_avail ? left_edge[8*i +: 8] : PAD_LEFT;
            data_next.x[6+i] = top_avail ? top_edge[8*i +: 8] : PAD_TOP;
            data_next.x[10+i] = top_right_avail ? top_right_edge[8*i +: 8] : t3;
        end
        data_next.x[0] = data_next.x[1];
        data_next.x[5] = corner_avail ? corner_pixel : (top_avail ? PAD_LEFT : PAD_TOP);
        data_next.x[14] = data_next.x[13];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/sip4_filt.sv
`default_nettype none

module sip4_filt (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sip4_pkg::edge_t    in_data,
    output logic                    out_valid,
    output sip4_pkg::filt_t         out_data
);
    import sip4_pkg::*;

    logic  valid_reg;
    filt_t data_reg;
    filt_t data_next;

    always_comb begin
        logic [10:0] sum;
        sum = 11'd4;
        for (int i = 0; i < 4; i++) begin
            sum = sum + {3'b000, in_data.x[1+i]} + {3'b000, in_data.x[6+i]};
        end
        data_next.kind = in_data.kind;
        data_next.dc   = sum[10:3];
        data_next.l3   = in_data.x[1];
        for (int i = 0; i < 4; i++) begin
            data_next.top[i] = in_data.x[6+i];
            data_next.lc[i]  = {1'b0, in_data.x[4-i]} - {1'b0, in_data.x[5]};
        end
        for (int k = 1; k <= 9; k++) begin
            data_next.a2[k] = avg2(in_data.x[k], in_data.x[k+1]);
        end
        for (int k = 0; k <= 12; k++) begin
            data_next.a3[k] = avg3(in_data.x[k], in_data.x[k+1], in_data.x[k+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/sip4_pred.sv
`default_nettype none

module sip4_pred (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sip4_pkg::filt_t    in_data,
    output logic                    out_valid,
    output logic [63:0]             rows_upper,
    output logic [63:0]             rows_lower
);
    import sip4_pkg::*;

    logic        valid_reg;
    pix_t [15:0] pix_reg;
    pix_t [15:0] pix_next;

    always_comb begin
        logic [9:0] s;
        s = '0;
        pix_next = '0;
        case (in_data.kind)
            MODE_DC: begin
                for (int i = 0; i < 16; i++) pix_next[i] = in_data.dc;
            end
            MODE_TM: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        s = {in_data.lc[r][8], in_data.lc[r]} + {2'b00, in_data.top[c]};
                        if (s[9]) begin
                            pix_next[r*4+c] = 8'd0;
                        end else if (s[8]) begin
                            pix_next[r*4+c] = 8'd255;
                        end else begin
                            pix_next[r*4+c] = s[7:0];
                        end
                    end
                end
            end
            MODE_VE: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) pix_next[r*4+c] = in_data.a3[5+c];
            end
            MODE_HE: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) pix_next[r*4+c] = in_data.a3[3-r];
            end
            MODE_LD: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) pix_next[r*4+c] = in_data.a3[6+r+c];
            end
            MODE_RD: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) pix_next[r*4+c] = in_data.a3[4-r+c];
            end
            MODE_VR: begin
                pix_next[12] = in_data.a3[2];
                pix_next[8]  = in_data.a3[3];
                pix_next[13] = in_data.a3[4];
                pix_next[4]  = in_data.a3[4];
                pix_next[9]  = in_data.a2[5];
                pix_next[0]  = in_data.a2[5];
                pix_next[14] = in_data.a3[5];
                pix_next[5]  = in_data.a3[5];
                pix_next[10] = in_data.a2[6];
                pix_next[1]  = in_data.a2[6];
                pix_next[15] = in_data.a3[6];
                pix_next[6]  = in_data.a3[6];
                pix_next[11] = in_data.a2[7];
                pix_next[2]  = in_data.a2[7];
                pix_next[7]  = in_data.a3[7];
                pix_next[3]  = in_data.a2[8];
            end
            MODE_VL: begin
                pix_next[0]  = in_data.a2[6];
                pix_next[4]  = in_data.a3[6];
                pix_next[8]  = in_data.a2[7];
                pix_next[1]  = in_data.a2[7];
                pix_next[5]  = in_data.a3[7];
                pix_next[12] = in_data.a3[7];
                pix_next[9]  = in_data.a2[8];
                pix_next[2]  = in_data.a2[8];
                pix_next[13] = in_data.a3[8];
                pix_next[6]  = in_data.a3[8];
                pix_next[10] = in_data.a2[9];
                pix_next[3]  = in_data.a2[9];
                pix_next[14] = in_data.a3[9];
                pix_next[7]  = in_data.a3[9];
                pix_next[11] = in_data.a3[10];
                pix_next[15] = in_data.a3[11];
            end
            MODE_HD: begin
                pix_next[12] = in_data.a2[1];
                pix_next[13] = in_data.a3[1];
                pix_next[8]  = in_data.a2[2];
                pix_next[14] = in_data.a2[2];
                pix_next[9]  = in_data.a3[2];
                pix_next[15] = in_data.a3[2];
                pix_next[10] = in_data.a2[3];
                pix_next[4]  = in_data.a2[3];
                pix_next[11] = in_data.a3[3];
                pix_next[5]  = in_data.a3[3];
                pix_next[6]  = in_data.a2[4];
                pix_next[0]  = in_data.a2[4];
                pix_next[7]  = in_data.a3[4];
                pix_next[1]  = in_data.a3[4];
                pix_next[2]  = in_data.a3[5];
                pix_next[3]  = in_data.a3[6];
            end
            MODE_HU: begin
                pix_next[0]  = in_data.a2[3];
                pix_next[1]  = in_data.a3[2];
                pix_next[2]  = in_data.a2[2];
                pix_next[4]  = in_data.a2[2];
                pix_next[3]  = in_data.a3[1];
                pix_next[5]  = in_data.a3[1];
                pix_next[6]  = in_data.a2[1];
                pix_next[8]  = in_data.a2[1];
                pix_next[7]  = in_data.a3[0];
                pix_next[9]  = in_data.a3[0];
                for (int i = 10; i < 16; i++) pix_next[i] = in_data.l3;
            end
            default: begin
                pix_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid  = valid_reg;
    assign rows_upper = pix_reg[7:0];
    assign rows_lower = pix_reg[15:8];

endmodule

`default_nettype wire

// File: rtl/subblock_intra_predictor_4x4.sv
`default_nettype none

// Predicts one 4x4 luma subblock per beat from its neighboring edge pixels, in any of the
// ten subblock modes; missing edges are replaced by the standard fill values first. The
// block is a three-stage pipeline (edge fill, filter taps, mode select with clamp), and one
// request can be taken every cycle while the output is not stalled. A stalled output holds
// a full stage in place only while every later stage is full too, and the stages behind an
// empty one keep moving; ready at the input is high whenever any stage has room.
module subblock_intra_predictor_4x4 (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [3:0]     s_kind,
    input  wire logic [31:0]    s_top_edge,
    input  wire logic [31:0]    s_top_right_edge,
    input  wire logic [31:0]    s_left_edge,
    input  wire logic [7:0]     s_corner_pixel,
    input  wire logic           s_top_avail,
    input  wire logic           s_left_avail,
    input  wire logic           s_corner_avail,
    input  wire logic           s_top_right_avail,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [63:0]         m_rows_upper,
    output logic [63:0]         m_rows_lower
);
    import sip4_pkg::*;

    logic  v1, v2;
    logic  en1, en2, en3;
    edge_t d1;
    filt_t d2;

    assign en3     = !m_valid || m_ready;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign s_ready = en1;

    sip4_edge u_edge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en1),
        .in_valid        (s_valid),
        .kind            (s_kind),
        .top_edge        (s_top_edge),
        .top_right_edge  (s_top_right_edge),
        .left_edge       (s_left_edge),
        .corner_pixel    (s_corner_pixel),
        .top_avail       (s_top_avail),
        .left_avail      (s_left_avail),
        .corner_avail    (s_corner_avail),
        .top_right_avail (s_top_right_avail),
        .out_valid       (v1),
        .out_data        (d1)
    );

    sip4_filt u_filt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    sip4_pred u_pred (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en3),
        .in_valid   (v2),
        .in_data    (d2),
        .out_valid  (m_valid),
        .rows_upper (m_rows_upper),
        .rows_lower (m_rows_lower)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sip4_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int IDLE_LIMIT      = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 500;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] top_edge;
        logic [31:0] top_right_edge;
        logic [31:0] left_edge;
        logic [7:0]  corner_pixel;
        logic        top_avail;
        logic        left_avail;
        logic        corner_avail;
        logic        top_right_avail;
    } subblock_req_t;

    class subblock_ledger;
        logic [63:0] upper_q[$];
        logic [63:0] lower_q[$];
        int          mismatches;
        int          rows_checked;

        function new();
            mismatches   = 0;
            rows_checked = 0;
        endfunction

        function pix_t mean2(int x, int y);
            return pix_t'((x + y + 1) >> 1);
        endfunction

        function pix_t mean3(int x, int y, int z);
            return pix_t'((x + 2 * y + z + 2) >> 2);
        endfunction

        function logic [127:0] predict_rows(subblock_req_t r);
            pix_t        t[8];
            pix_t        l[4];
            pix_t        e[9];
            pix_t        p[16];
            pix_t        c;
            int          s;
            int          v;
            int          k;
            logic [63:0] up;
            logic [63:0] lo;
            for (int i = 0; i < 4; i++) begin
                t[i] = r.top_avail ? r.top_edge[8*i +: 8] : PAD_TOP;
                l[i] = r.left_avail ? r.left_edge[8*i +: 8] : PAD_LEFT;
            end
            for (int i = 0; i < 4; i++) begin
                t[4+i] = r.top_right_avail ? r.top_right_edge[8*i +: 8] : t[3];
            end
            c = r.corner_avail ? r.corner_pixel : (r.top_avail ? PAD_LEFT : PAD_TOP);
            e = '{l[3], l[2], l[1], l[0], c, t[0], t[1], t[2], t[3]};
            for (int i = 0; i < 16; i++) begin
                p[i] = 8'd0;
            end
            case (r.kind)
                MODE_DC: begin
                    s = 4;
                    for (int i = 0; i < 4; i++) begin
                        s += t[i] + l[i];
                    end
                    for (int i = 0; i < 16; i++) begin
                        p[i] = pix_t'(s >> 3);
                    end
                end
                MODE_TM: begin
                    for (int row = 0; row < 4; row++) begin
                        for (int col = 0; col < 4; col++) begin
                            v = int'(l[row]) + int'(t[col]) - int'(c);
                            if (v < 0) begin
                                v = 0;
                            end
                            if (v > 255) begin
                                v = 255;
                            end
                            p[row*4+col] = pix_t'(v);
                        end
                    end
                end
                MODE_VE: begin
                    for (int col = 0; col < 4; col++) begin
                        for (int row = 0; row < 4; row++) begin
                            p[row*4+col] = mean3(col == 0 ? c : t[col-1], t[col], t[col+1]);
                        end
                    end
                end
                MODE_HE: begin
                    for (int row = 0; row < 4; row++) begin
                        for (int col = 0; col < 4; col++) begin
                            p[row*4+col] = mean3(row == 0 ? c : l[row-1], l[row],
                                                 row == 3 ? l[3] : l[row+1]);
                        end
                    end
                end
                MODE_LD: begin
                    for (int row = 0; row < 4; row++) begin
                        for (int col = 0; col < 4; col++) begin
                            k = row + col;
                            p[row*4+col] = (k == 6) ? mean3(t[6], t[7], t[7])
                                                    : mean3(t[k], t[k+1], t[k+2]);
                        end
                    end
                end
                MODE_RD: begin
                    for (int row = 0; row < 4; row++) begin
                        for (int col = 0; col < 4; col++) begin
                            k = 3 - row + col;
                            p[row*4+col] = mean3(e[k], e[k+1], e[k+2]);
                        end
                    end
                end
                MODE_VR: begin
                    p[12] = mean3(e[1], e[2], e[3]);
                    p[8]  = mean3(e[2], e[3], e[4]);
                    p[13] = mean3(e[3], e[4], e[5]);
                    p[4]  = p[13];
                    p[9]  = mean2(e[4], e[5]);
                    p[0]  = p[9];
                    p[14] = mean3(e[4], e[5], e[6]);
                    p[5]  = p[14];
                    p[10] = mean2(e[5], e[6]);
                    p[1]  = p[10];
                    p[15] = mean3(e[5], e[6], e[7]);
                    p[6]  = p[15];
                    p[11] = mean2(e[6], e[7]);
                    p[2]  = p[11];
                    p[7]  = mean3(e[6], e[7], e[8]);
                    p[3]  = mean2(e[7], e[8]);
                end
                MODE_VL: begin
                    p[0]  = mean2(t[0], t[1]);
                    p[4]  = mean3(t[0], t[1], t[2]);
                    p[8]  = mean2(t[1], t[2]);
                    p[1]  = p[8];
                    p[5]  = mean3(t[1], t[2], t[3]);
                    p[12] = p[5];
                    p[9]  = mean2(t[2], t[3]);
                    p[2]  = p[9];
                    p[13] = mean3(t[2], t[3], t[4]);
                    p[6]  = p[13];
                    p[10] = mean2(t[3], t[4]);
                    p[3]  = p[10];
                    p[14] = mean3(t[3], t[4], t[5]);
                    p[7]  = p[14];
                    p[11] = mean3(t[4], t[5], t[6]);
                    p[15] = mean3(t[5], t[6], t[7]);
                end
                MODE_HD: begin
                    p[12] = mean2(e[0], e[1]);
                    p[13] = mean3(e[0], e[1], e[2]);
                    p[8]  = mean2(e[1], e[2]);
                    p[14] = p[8];
                    p[9]  = mean3(e[1], e[2], e[3]);
                    p[15] = p[9];
                    p[10] = mean2(e[2], e[3]);
                    p[4]  = p[10];
                    p[11] = mean3(e[2], e[3], e[4]);
                    p[5]  = p[11];
                    p[6]  = mean2(e[3], e[4]);
                    p[0]  = p[6];
                    p[7]  = mean3(e[3], e[4], e[5]);
                    p[1]  = p[7];
                    p[2]  = mean3(e[4], e[5], e[6]);
                    p[3]  = mean3(e[5], e[6], e[7]);
                end
                MODE_HU: begin
                    p[0] = mean2(l[0], l[1]);
                    p[1] = mean3(l[0], l[1], l[2]);
                    p[2] = mean2(l[1], l[2]);
                    p[4] = p[2];
                    p[3] = mean3(l[1], l[2], l[3]);
                    p[5] = p[3];
                    p[6] = mean2(l[2], l[3]);
                    p[8] = p[6];
                    p[7] = mean3(l[2], l[3], l[3]);
                    p[9] = p[7];
                    for (int i = 10; i < 16; i++) begin
                        p[i] = l[3];
                    end
                end
                default: begin
                end
            endcase
            for (int i = 0; i < 8; i++) begin
                up[8*i +: 8] = p[i];
                lo[8*i +: 8] = p[8+i];
            end
            return {lo, up};
        endfunction

        function void note_request(subblock_req_t r);
            logic [127:0] rows;
            rows = predict_rows(r);
            upper_q.push_back(rows[63:0]);
            lower_q.push_back(rows[127:64]);
        endfunction

        function void check_rows(logic [63:0] upper, logic [63:0] lower);
            logic [63:0] want_upper;
            logic [63:0] want_lower;
            if (upper_q.size() == 0) begin
                $display("%0t: result beat with no request pending, upper %h lower %h",
                         $time, upper, lower);
                mismatches++;
                return;
            end
            want_upper = upper_q.pop_front();
            want_lower = lower_q.pop_front();
            rows_checked++;
            if (upper !== want_upper) begin
                $display("%0t: m_rows_upper expected %h actual %h", $time, want_upper, upper);
                mismatches++;
            end
            if (lower !== want_lower) begin
                $display("%0t: m_rows_lower expected %h actual %h", $time, want_lower, lower);
                mismatches++;
            end
        endfunction

        function int pending();
            return upper_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_kind;
    logic [31:0] s_top_edge;
    logic [31:0] s_top_right_edge;
    logic [31:0] s_left_edge;
    logic [7:0]  s_corner_pixel;
    logic        s_top_avail;
    logic        s_left_avail;
    logic        s_corner_avail;
    logic        s_top_right_avail;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_rows_upper;
    logic [63:0] m_rows_lower;

    subblock_ledger ledger;
    int             requests_taken = 0;
    int             unused_kinds = 0;
    int             input_stalls = 0;
    bit             hold_active = 1'b0;
    bit             hold_done = 1'b0;

    subblock_intra_predictor_4x4 u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_top_edge        (s_top_edge),
        .s_top_right_edge  (s_top_right_edge),
        .s_left_edge       (s_left_edge),
        .s_corner_pixel    (s_corner_pixel),
        .s_top_avail       (s_top_avail),
        .s_left_avail      (s_left_avail),
        .s_corner_avail    (s_corner_avail),
        .s_top_right_avail (s_top_right_avail),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rows_upper      (m_rows_upper),
        .m_rows_lower      (m_rows_lower)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] pixel_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: begin
                for (int i = 0; i < 4; i++) begin
                    w[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            end
            1: begin
                w = {4{8'($urandom_range(0, 255))}};
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    function automatic subblock_req_t make_request(logic [3:0] kind, logic [31:0] top,
                                                   logic [31:0] top_right, logic [31:0] left,
                                                   logic [7:0] corner, logic [3:0] avail);
        subblock_req_t r;
        r.kind            = kind;
        r.top_edge        = top;
        r.top_right_edge  = top_right;
        r.left_edge       = left;
        r.corner_pixel    = corner;
        r.top_avail       = avail[3];
        r.left_avail      = avail[2];
        r.corner_avail    = avail[1];
        r.top_right_avail = avail[0];
        return r;
    endfunction

    function automatic subblock_req_t random_request();
        logic [3:0]  kind;
        logic [31:0] corner_word;
        logic [3:0]  avail;
        kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
        corner_word = pixel_word();
        for (int i = 0; i < 4; i++) begin
            avail[i] = ($urandom_range(0, 3) != 0);
        end
        return make_request(kind, pixel_word(), pixel_word(), pixel_word(),
                            corner_word[7:0], avail);
    endfunction

    task automatic offer_request(input subblock_req_t r);
        @(negedge aclk);
        s_valid           = 1'b1;
        s_kind            = r.kind;
        s_top_edge        = r.top_edge;
        s_top_right_edge  = r.top_right_edge;
        s_left_edge       = r.left_edge;
        s_corner_pixel    = r.corner_pixel;
        s_top_avail       = r.top_avail;
        s_left_avail      = r.left_avail;
        s_corner_avail    = r.corner_avail;
        s_top_right_avail = r.top_right_avail;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        ledger.note_request(r);
        requests_taken++;
        if (r.kind > 4'(MODE_HU)) begin
            unused_kinds++;
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_rows(m_rows_upper, m_rows_lower);
        end
        if (aresetn && s_valid && !s_ready) begin
            input_stalls++;
        end
    end

    // The receiver switches between stall patterns, and once holds off long enough for
    // the pipeline to fill and push back on the sender.
    initial begin
        int style;
        int left_in_style;
        int phase;
        m_ready       = 1'b0;
        style         = 0;
        left_in_style = 0;
        phase         = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && requests_taken >= HOLD_AFTER) begin
                hold_active = 1'b1;
                m_ready     = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            if (left_in_style == 0) begin
                style         = $urandom_range(0, 3);
                left_in_style = $urandom_range(50, 150);
            end
            left_in_style--;
            phase++;
            case (style)
                0: m_ready = 1'b1;
                1: m_ready = $urandom_range(0, 1);
                2: m_ready = (phase % 4 != 3);
                default: m_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int burst;
        int sent;
        ledger            = new();
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_kind            = '0;
        s_top_edge        = '0;
        s_top_right_edge  = '0;
        s_left_edge       = '0;
        s_corner_pixel    = '0;
        s_top_avail       = 1'b0;
        s_left_avail      = 1'b0;
        s_corner_avail    = 1'b0;
        s_top_right_avail = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int k = 0; k < 16; k++) begin
            offer_request(make_request(4'(k), $urandom, $urandom, $urandom,
                                       8'($urandom), 4'(k + 15)));
        end
        offer_request(make_request(MODE_TM, 32'h0, 32'h0, 32'h0, 8'hFF, 4'b1111));
        offer_request(make_request(MODE_TM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   8'h00, 4'b1111));
        offer_request(make_request(MODE_DC, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b0000));
        offer_request(make_request(MODE_DC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   8'hFF, 4'b1111));
        offer_request(make_request(MODE_VE, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b1101));
        offer_request(make_request(MODE_RD, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b0100));
        offer_request(make_request(MODE_LD, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b1110));
        offer_request(make_request(MODE_VL, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b0110));
        offer_request(make_request(MODE_HU, $urandom, $urandom, $urandom, 8'($urandom),
                                   4'b1011));

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
                offer_request(random_request());
                sent++;
            end
            if (!hold_active && $urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
        pause_sender(1);

        while (ledger.pending() > 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("tb: %0d subblock requests over all 16 mode codes (%0d unused codes),",
                 requests_taken, unused_kinds);
        $display("tb: %0d results checked, %0d input stall cycles, %0d mismatches",
                 ledger.rows_checked, input_stalls, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/sip4_pkg.sv
rtl/sip4_edge.sv
rtl/sip4_filt.sv
rtl/sip4_pred.sv
rtl/subblock_intra_predictor_4x4.sv
tb/tb.sv
